[design/polyblep_wave_oscillator_macros.svh]
// Assertion macros for the oscillator.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef POLYBLEP_WAVE_OSCILLATOR_MACROS_SVH
`define POLYBLEP_WAVE_OSCILLATOR_MACROS_SVH

// Checked on every clock edge outside reset.
`define PBO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PBO_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/pbo_pkg.sv]
// Shared types, constants and the sine table function of the oscillator.
// No dependencies.
package pbo_pkg;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_CLAMP, ST_BLEP, ST_DIV, ST_SQUARE, ST_COMBINE,
      ST_TRI_STEP, ST_TRI_LEAK, ST_SCALE, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OSC_SINE, OSC_SAW, OSC_SQUARE, OSC_TRIANGLE
   } wave_type;

   typedef enum logic [1:0] {
      REG_WAVEFORM, REG_BASE_INC, REG_MIN_INC, REG_BASE_AMP
   } reg_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   localparam int CSR_DATA_W = 31;
   localparam int DIV_STEPS  = 16;
   localparam int MUL_STEPS  = 16;

   localparam logic [30:0] MAX_INCREMENT  = 31'd1932735283;
   localparam logic [30:0] BASE_INC_RESET = 31'd39370534;
   localparam logic [30:0] MIN_INC_RESET  = 31'd895;
   localparam logic [16:0] BASE_AMP_RESET = 17'd32768;
   localparam logic [16:0] ONE_Q16        = 17'd65536;
   localparam logic signed [24:0] LEAK_Q24 = 25'sd16760439;
   localparam logic signed [27:0] TRI_ONE  = 28'sd4194304;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // sin(x) for x in [0, pi/2] given in Q30, by a nine-term Taylor series;
   // rounded to Q1.15. Used at elaboration to fill the quarter-wave table.
   function automatic logic [15:0] quarter_sine(input longint unsigned x);
      longint sum;
      longint unsigned term;
      longint unsigned r;
      sum  = $signed(x);
      term = x;
      for (int k = 1; k <= 8; k++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = ($unsigned(sum) + 64'd16384) >> 15;
      return 16'(r);
   endfunction

endpackage

[design/pbo_div.sv]
// Radix-2 restoring divider for the PolyBLEP ratio: floor(num * 2^16 / den).
// Depends on pbo_pkg. The numerator must be below the denominator.
module pbo_div
   import pbo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [30:0]    num,
   input  logic [30:0]    den,
   output logic [15:0]    quotient,
   output div_status_type status
);

   logic [30:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [30:0] den_ff, den_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] rem_dbl;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_dbl = {rem_ff, 1'b0};
      if (start) begin
         rem_in  = num;
         den_in  = den;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // One quotient bit per cycle; the remainder stays below the divisor.
         if (rem_dbl >= {1'b0, den_ff}) begin
            rem_in = 31'(rem_dbl - {1'b0, den_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_dbl[30:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/polyblep_wave_oscillator.sv]
// PolyBLEP oscillator top level; depends on pbo_pkg, pbo_div and the macros header.
// One request at a time, one response per request. Each sample passes through the
// bit-serial frequency multiplier and, for saw, square and triangle, up to two
// divider passes; a new request is taken once the block is idle again after each
// response is registered, and a stalled response holds the input.
// Synchronous active-high reset clears phase and triangle level and restores registers and control.
`include "polyblep_wave_oscillator_macros.svh"

module polyblep_wave_oscillator
   import pbo_pkg::*;
#(
   parameter int SINE_ENTRIES = 1024,
   parameter int PHASE_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [15:0]     req_freq_mod,
   input  logic signed [15:0]     req_amp_mod,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [17:0]     rsp_sample,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LOG2N = $clog2(SINE_ENTRIES);
   localparam int QBITS = LOG2N - 2;
   localparam int QN    = SINE_ENTRIES / 4;
   localparam int SH    = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 32 - PHASE_BITS;

   // Quarter-wave sine table, Q1.15 magnitudes, including the peak entry.
   logic [15:0] quarter_rom [QN+1];
   for (genvar g = 0; g <= QN; g++) begin : g_rom
      localparam longint unsigned ARG = HALF_PI_Q30 * 64'(4 * g) / 64'(SINE_ENTRIES);
      assign quarter_rom[g] = quarter_sine(ARG);
   end

   state_type state_ff, state_in;
   logic [1:0]            wave_ff, wave_in;
   logic [30:0]           base_inc_ff, base_inc_in;
   logic [30:0]           min_inc_ff, min_inc_in;
   logic [16:0]           base_amp_ff, base_amp_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic signed [23:0]    level_ff, level_in;
   logic [15:0]           mplier_ff, mplier_in;
   logic [46:0]           acc_ff, acc_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [16:0]           gain_ff, gain_in;
   logic [30:0]           inc_ff, inc_in;
   logic                  blep_sel_ff, blep_sel_in;
   logic                  blep_neg_ff, blep_neg_in;
   logic signed [17:0]    blep_a_ff, blep_a_in;
   logic signed [17:0]    blep_b_ff, blep_b_in;
   logic signed [19:0]    value_ff, value_in;
   logic signed [26:0]    tsum_ff, tsum_in;
   logic signed [37:0]    prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [17:0]    rsp_sample_ff, rsp_sample_in;
   logic [15:0]           rom_q_ff;
   logic                  rom_neg_ff;

   logic [31:0]           t;
   logic [PHASE_BITS-1:0] step;
   logic [LOG2N-1:0]      sine_idx;
   logic [QBITS:0]        rom_addr;

   logic                  div_start;
   logic [30:0]           div_num;
   logic [15:0]           div_quo;
   div_status_type        div_status;

   // Phase taken to a 32-bit cycle fraction, and the increment taken to phase width.
   if (PHASE_BITS >= 32) begin : g_wide_phase
      assign t    = 32'(phase_ff >> SH);
      assign step = PHASE_BITS'(inc_ff) << SH;
   end else begin : g_narrow_phase
      assign t    = 32'(phase_ff) << SH;
      assign step = PHASE_BITS'(inc_ff >> SH);
   end

   assign sine_idx = t[31 -: LOG2N];
   assign rom_addr = sine_idx[QBITS] ? (QBITS+1)'(QN) - {1'b0, sine_idx[QBITS-1:0]}
                                     : {1'b0, sine_idx[QBITS-1:0]};

   always_ff @(posedge clock) begin
      rom_q_ff   <= quarter_rom[rom_addr];
      rom_neg_ff <= sine_idx[LOG2N-1];
   end

   pbo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (inc_ff),
      .quotient (div_quo),
      .status   (div_status)
   );

   logic signed [18:0] gain_sum;
   logic [31:0]        raw_inc;
   logic [31:0]        tb;
   logic [32:0]        tb_plus;
   logic [16:0]        blep_d;
   logic [33:0]        blep_dd;
   logic signed [17:0] blep_val;
   logic signed [19:0] sq_val;
   logic signed [19:0] saw_val;
   logic signed [19:0] sine_val;
   logic signed [51:0] tri_prod;
   logic signed [51:0] leak_prod;
   logic signed [27:0] leaked;
   logic signed [27:0] tri_clamped;
   logic signed [20:0] y_shift;

   always_comb begin
      state_in      = state_ff;
      wave_in       = wave_ff;
      base_inc_in   = base_inc_ff;
      min_inc_in    = min_inc_ff;
      base_amp_in   = base_amp_ff;
      phase_in      = phase_ff;
      level_in      = level_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      gain_in       = gain_ff;
      inc_in        = inc_ff;
      blep_sel_in   = blep_sel_ff;
      blep_neg_in   = blep_neg_ff;
      blep_a_in     = blep_a_ff;
      blep_b_in     = blep_b_ff;
      value_in      = value_ff;
      tsum_in       = tsum_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      req_ready     = 1'b0;
      div_start     = 1'b0;
      div_num       = '0;

      gain_sum  = $signed({2'b00, base_amp_ff})
                + $signed({{2{req_amp_mod[15]}}, req_amp_mod, 1'b0});
      raw_inc   = acc_ff[46:15];
      tb        = blep_sel_ff ? t + 32'h8000_0000 : t;
      tb_plus   = {1'b0, tb} + {2'b00, inc_ff};
      blep_d    = ONE_Q16 - {1'b0, div_quo};
      blep_dd   = (blep_d * blep_d) >> 16;
      blep_val  = blep_neg_ff ? -$signed(18'(blep_dd)) : $signed(18'(blep_dd));
      sq_val    = (t[31] ? -20'sd65536 : 20'sd65536) + 20'(blep_a_ff) - 20'(blep_b_ff);
      saw_val   = $signed({3'b000, t[31:16], 1'b0}) - 20'sd65536 - 20'(blep_a_ff);
      sine_val  = rom_neg_ff ? -$signed({3'b000, rom_q_ff, 1'b0})
                             : $signed({3'b000, rom_q_ff, 1'b0});
      tri_prod  = $signed({1'b0, inc_ff}) * sq_val;
      leak_prod = tsum_ff * LEAK_Q24;
      leaked    = 28'(leak_prod >>> 24);
      if (leaked > TRI_ONE) begin
         tri_clamped = TRI_ONE;
      end else if (leaked < -TRI_ONE) begin
         tri_clamped = -TRI_ONE;
      end else begin
         tri_clamped = leaked;
      end
      y_shift = 21'(prod_ff >>> 17);

      if (csr_write) begin
         case (csr_index)
            REG_WAVEFORM: wave_in     = csr_data[1:0];
            REG_BASE_INC: base_inc_in = csr_data[30:0];
            REG_MIN_INC:  min_inc_in  = csr_data[30:0];
            REG_BASE_AMP: base_amp_in = csr_data[16:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mplier_in = {~req_freq_mod[15], req_freq_mod[14:0]};
               acc_in    = '0;
               cnt_in    = '0;
               if (gain_sum < 0) begin
                  gain_in = '0;
               end else if (gain_sum > $signed({2'b00, ONE_Q16})) begin
                  gain_in = ONE_Q16;
               end else begin
                  gain_in = 17'(gain_sum);
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // Most significant multiplier bit first.
            acc_in    = {acc_ff[45:0], 1'b0} + (mplier_ff[15] ? 47'(base_inc_ff) : 47'd0);
            mplier_in = {mplier_ff[14:0], 1'b0};
            cnt_in    = cnt_ff + 4'd1;
            if (cnt_ff == 4'(MUL_STEPS - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            // The lower bound goes first, so the upper bound wins when they cross.
            if (raw_inc < {1'b0, min_inc_ff}) begin
               inc_in = (min_inc_ff > MAX_INCREMENT) ? MAX_INCREMENT : min_inc_ff;
            end else if (raw_inc > {1'b0, MAX_INCREMENT}) begin
               inc_in = MAX_INCREMENT;
            end else begin
               inc_in = raw_inc[30:0];
            end
            blep_sel_in = 1'b0;
            state_in    = (wave_ff == OSC_SINE) ? ST_COMBINE : ST_BLEP;
         end
         ST_BLEP: begin
            if ({1'b0, tb} < {2'b00, inc_ff}) begin
               div_num     = tb[30:0];
               div_start   = 1'b1;
               blep_neg_in = 1'b1;
               state_in    = ST_DIV;
            end else if (tb_plus > 33'h1_0000_0000) begin
               div_num     = 31'(33'h1_0000_0000 - {1'b0, tb});
               div_start   = 1'b1;
               blep_neg_in = 1'b0;
               state_in    = ST_DIV;
            end else begin
               // Away from both edges the correction is zero.
               if (blep_sel_ff) begin
                  blep_b_in = '0;
                  state_in  = ST_COMBINE;
               end else begin
                  blep_a_in   = '0;
                  blep_sel_in = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (blep_sel_ff) begin
               blep_b_in = blep_val;
               state_in  = ST_COMBINE;
            end else begin
               blep_a_in   = blep_val;
               blep_sel_in = 1'b1;
               state_in    = ST_BLEP;
            end
         end
         ST_COMBINE: begin
            case (wave_ff)
               OSC_SINE: begin
                  value_in = sine_val;
                  state_in = ST_SCALE;
               end
               OSC_SAW: begin
                  value_in = saw_val;
                  state_in = ST_SCALE;
               end
               OSC_SQUARE: begin
                  value_in = sq_val;
                  state_in = ST_SCALE;
               end
               default: begin
                  state_in = ST_TRI_STEP;
               end
            endcase
         end
         ST_TRI_STEP: begin
            tsum_in  = 27'(level_ff) + 27'(tri_prod >>> 25);
            state_in = ST_TRI_LEAK;
         end
         ST_TRI_LEAK: begin
            level_in = 24'(tri_clamped);
            value_in = 20'(tri_clamped >>> 5);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            prod_in  = $signed({1'b0, gain_ff}) * value_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (y_shift > 21'sd131071) begin
                  rsp_sample_in = 18'sd131071;
               end else if (y_shift < -21'sd131072) begin
                  rsp_sample_in = -18'sd131072;
               end else begin
                  rsp_sample_in = 18'(y_shift);
               end
               rsp_valid_in = 1'b1;
               phase_in     = phase_ff + step;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wave_ff      <= OSC_SINE;
         base_inc_ff  <= BASE_INC_RESET;
         min_inc_ff   <= MIN_INC_RESET;
         base_amp_ff  <= BASE_AMP_RESET;
         phase_ff     <= '0;
         level_ff     <= '0;
         cnt_ff       <= '0;
         blep_sel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wave_ff      <= wave_in;
         base_inc_ff  <= base_inc_in;
         min_inc_ff   <= min_inc_in;
         base_amp_ff  <= base_amp_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         cnt_ff       <= cnt_in;
         blep_sel_ff  <= blep_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      gain_ff       <= gain_in;
      inc_ff        <= inc_in;
      blep_neg_ff   <= blep_neg_in;
      blep_a_ff     <= blep_a_in;
      blep_b_ff     <= blep_b_in;
      value_ff      <= value_in;
      tsum_ff       <= tsum_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   `PBO_ASSERT(a_accept_starts_mul, req_valid && req_ready |=> state_ff == ST_MUL, "accepted request did not start the multiplier")
   `PBO_ASSERT(a_inc_bounded, state_ff == ST_BLEP |-> inc_ff <= MAX_INCREMENT, "increment above the upper bound")
   `PBO_ASSERT(a_level_bounded, level_ff <= 24'sd4194304 && level_ff >= -24'sd4194304, "triangle level out of range")
   `PBO_ASSERT(a_div_done_in_div, div_status.done |-> state_ff == ST_DIV, "divider finished outside the divide state")

endmodule

[tb/polyblep_wave_oscillator_tb.sv]
// Testbench for the PolyBLEP oscillator: drives requests and register writes,
// predicts every sample in SystemVerilog and checks the responses in order.
// Depends on pbo_pkg and the polyblep_wave_oscillator top level.
`timescale 1ns / 1ps

module polyblep_wave_oscillator_tb
   import pbo_pkg::*;
();

   localparam int TABLE_SIZE  = 1024;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 100;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic signed [15:0]    req_freq_mod;
   logic signed [15:0]    req_amp_mod;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic signed [17:0]    rsp_sample;
   logic                  csr_write;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   polyblep_wave_oscillator u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_freq_mod (req_freq_mod),
      .req_amp_mod  (req_amp_mod),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_sample   (rsp_sample),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Predictor state, mirrors the block's registers and accumulators.
   wave_type        osc_wave;
   logic [30:0]     osc_base_inc;
   logic [30:0]     osc_min_inc;
   logic [16:0]     osc_base_amp;
   logic [31:0]     osc_phase;
   longint          osc_tri_level;
   longint          sine_lut [TABLE_SIZE];

   logic signed [17:0] expected_samples [$];
   int unsigned        error_count;
   int unsigned        cycle_count;
   bit                 steady_flow;
   bit                 hold_request;
   int unsigned        hold_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off when a test asks for it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_count = 400;
         rsp_ready <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count = hold_count - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady_flow || ($urandom_range(99) >= 38);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t unexpected sample: expected none actual %0d", $time, rsp_sample);
            error_count++;
         end else begin
            if (rsp_sample !== expected_samples[0]) begin
               $display("%0t sample mismatch: expected %0d actual %0d",
                        $time, expected_samples[0], rsp_sample);
               error_count++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   function automatic longint sine_q15(longint unsigned x);
      longint          acc;
      longint unsigned term;
      acc  = longint'(x);
      term = x;
      for (int k = 1; k <= 8; k++) begin
         term = (((term * x) >> 30) * x) >> 30;
         term = term / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return (acc + 16384) >> 15;
   endfunction

   task automatic fill_sine_lut();
      longint unsigned q, r, frac;
      longint          s;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         q    = (4 * i) / TABLE_SIZE;
         r    = (4 * i) % TABLE_SIZE;
         frac = q[0] ? (TABLE_SIZE - r) : r;
         s    = sine_q15(HALF_PI_Q30 * frac / TABLE_SIZE);
         sine_lut[i] = (q >= 2) ? -s : s;
      end
   endtask

   // Band-limiting residual in Q16 around a discontinuity at phase zero.
   function automatic longint blep_residual(longint t, longint dt);
      longint d;
      if (dt == 0) begin
         return 0;
      end
      if (t < dt) begin
         d = 65536 - ((t << 16) / dt);
         return -((d * d) >>> 16);
      end
      if (t + dt > 64'h1_0000_0000) begin
         d = 65536 - (((64'h1_0000_0000 - t) << 16) / dt);
         return (d * d) >>> 16;
      end
      return 0;
   endfunction

   function automatic longint square_value(longint t, longint dt);
      longint v;
      v = (t < 64'h8000_0000) ? 65536 : -65536;
      v = v + blep_residual(t, dt);
      v = v - blep_residual((t + 64'h8000_0000) & 64'hFFFF_FFFF, dt);
      return v;
   endfunction

   task automatic predict_sample(input logic signed [15:0] fm, input logic signed [15:0] am);
      longint inc, gain, t, value, tri_acc, y;
      inc = (longint'(osc_base_inc) * (32768 + longint'(fm))) >> 15;
      if (inc < longint'(osc_min_inc)) begin
         inc = longint'(osc_min_inc);
      end
      if (inc > longint'(MAX_INCREMENT)) begin
         inc = longint'(MAX_INCREMENT);
      end
      gain = longint'(osc_base_amp) + 2 * longint'(am);
      if (gain < 0) begin
         gain = 0;
      end
      if (gain > 65536) begin
         gain = 65536;
      end
      t = longint'(osc_phase);
      case (osc_wave)
         OSC_SINE: begin
            value = 2 * sine_lut[(t * TABLE_SIZE) >> 32];
         end
         OSC_SAW: begin
            value = 2 * (t >> 16) - 65536 - blep_residual(t, inc);
         end
         OSC_SQUARE: begin
            value = square_value(t, inc);
         end
         default: begin
            tri_acc = osc_tri_level + ((inc * square_value(t, inc)) >>> 25);
            tri_acc = (tri_acc * longint'(LEAK_Q24)) >>> 24;
            if (tri_acc > longint'(TRI_ONE)) begin
               tri_acc = longint'(TRI_ONE);
            end
            if (tri_acc < -longint'(TRI_ONE)) begin
               tri_acc = -longint'(TRI_ONE);
            end
            osc_tri_level = tri_acc;
            value = tri_acc >>> 5;
         end
      endcase
      y = (gain * value) >>> 17;
      if (y > 131071) begin
         y = 131071;
      end
      if (y < -131072) begin
         y = -131072;
      end
      expected_samples.push_back(18'(y));
      osc_phase = 32'(longint'(osc_phase) + inc);
   endtask

   // Offers one request, optionally after a random gap, and waits for acceptance.
   task automatic send_tick(input logic signed [15:0] fm, input logic signed [15:0] am);
      if (!steady_flow && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_freq_mod <= fm;
      req_amp_mod  <= am;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_sample(fm, am);
   endtask

   task automatic send_random_tick();
      send_tick(16'($urandom), 16'($urandom));
   endtask

   // Lets every outstanding response arrive, then lets the datapath settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_WAVEFORM: osc_wave     = wave_type'(value[1:0]);
         REG_BASE_INC: osc_base_inc = value[30:0];
         REG_MIN_INC:  osc_min_inc  = value[30:0];
         default:      osc_base_amp = value[16:0];
      endcase
   endtask

   task automatic set_all(input logic [1:0] wave, input logic [30:0] base,
                          input logic [30:0] min_inc, input logic [16:0] amp);
      write_reg(REG_WAVEFORM, {29'($urandom), wave});
      write_reg(REG_BASE_INC, base);
      write_reg(REG_MIN_INC, min_inc);
      write_reg(REG_BASE_AMP, {14'd0, amp});
   endtask

   task automatic test_reset_defaults();
      repeat (6) send_random_tick();
      drain();
   endtask

   // Modulation extremes on every waveform with the base amplitude at exactly one.
   task automatic test_extremes();
      for (int w = 0; w < 4; w++) begin
         set_all(2'(w), 31'(BASE_INC_RESET * 8), MIN_INC_RESET, ONE_Q16);
         send_tick(-16'sd32768, -16'sd32768);
         send_tick(16'sd32767, 16'sd32767);
         send_tick(16'sd0, 16'sd0);
         send_tick(16'sd32767, -16'sd32768);
         drain();
      end
   endtask

   // Zero increment, crossed bounds, gain register past one.
   task automatic test_special_cases();
      set_all(OSC_SAW, 31'd0, 31'd0, 17'h1FFFF);
      send_tick(16'sd32767, 16'sd0);
      send_tick(16'sd0, -16'sd32768);
      drain();
      set_all(OSC_SQUARE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 17'd0);
      send_tick(-16'sd32768, 16'sd32767);
      send_tick(16'sd32767, 16'sd100);
      drain();
      set_all(OSC_TRIANGLE, 31'd0, 31'd0, ONE_Q16);
      send_tick(16'sd0, 16'sd0);
      send_tick(-16'sd32768, 16'sd0);
      drain();
   endtask

   task automatic random_config();
      logic [30:0] base, min_inc;
      logic [16:0] amp;
      case ($urandom_range(3))
         0: base = 31'($urandom);
         1: base = 31'($urandom_range(400000000));
         2: base = 31'($urandom_range(4000000));
         default: base = ($urandom_range(1) != 0) ? 31'h7FFF_FFFF : 31'd0;
      endcase
      case ($urandom_range(3))
         0: min_inc = 31'($urandom);
         1: min_inc = 31'($urandom_range(2000));
         2: min_inc = 31'h7FFF_FFFF;
         default: min_inc = 31'd0;
      endcase
      case ($urandom_range(3))
         0: amp = 17'($urandom);
         1: amp = ONE_Q16;
         2: amp = 17'd0;
         default: amp = 17'($urandom_range(65536));
      endcase
      set_all(2'($urandom), base, min_inc, amp);
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 6; phase++) begin
         random_config();
         steady_flow = (phase == 2);
         repeat (55) send_random_tick();
         steady_flow = 1'b0;
         drain();
      end
   endtask

   // The response side holds off while requests keep coming, so the input stalls.
   task automatic test_backpressure();
      random_config();
      hold_request = 1'b1;
      repeat (12) send_random_tick();
      drain();
   endtask

   // A stop on the request side until every response is back, then more.
   task automatic test_sender_pause();
      write_reg(REG_WAVEFORM, 31'(OSC_TRIANGLE));
      repeat (15) send_random_tick();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (15) send_random_tick();
      drain();
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_freq_mod = '0;
      req_amp_mod  = '0;
      csr_write    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      rsp_ready    = 1'b0;
      error_count  = 0;
      cycle_count  = 0;
      steady_flow  = 1'b0;
      hold_request = 1'b0;
      hold_count   = 0;
      osc_wave      = OSC_SINE;
      osc_base_inc  = BASE_INC_RESET;
      osc_min_inc   = MIN_INC_RESET;
      osc_base_amp  = BASE_AMP_RESET;
      osc_phase     = '0;
      osc_tri_level = 0;
      fill_sine_lut();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_extremes();
      test_special_cases();
      test_random();
      test_backpressure();
      test_sender_pause();

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[polyblep_wave_oscillator.f]
+incdir+design
design/pbo_pkg.sv
design/pbo_div.sv
design/polyblep_wave_oscillator.sv
tb/polyblep_wave_oscillator_tb.sv
